/* sv/rsmp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsmp_pkg: shared constants for the linear interpolation resampler
// Sample, step and position widths, Q8.16 position and Q7.16 step unity and parameter defaults.
// ---------------------------------------------------------------------------
package rsmp_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STEP_W   = 23;
   localparam int POS_W    = 24;
   localparam int FRAC_W   = 16;
   localparam int DIVD_W   = FRAC_W + 1;

   localparam logic [POS_W-1:0]  POS_ONE    = POS_W'(1) << FRAC_W;
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_W;

   localparam int DEF_MAX_UPSAMPLE  = 8;
   localparam int DEF_FRACTION_BITS = 16;

endpackage

/* sv/rsmp_interp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsmp_interp: weighted blend of two samples
// Registers (b - a) * w, then adds a scaled by unity and truncates toward zero.
// ---------------------------------------------------------------------------
module rsmp_interp #(
   parameter int FRACTION_BITS = rsmp_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [rsmp_pkg::SAMPLE_W-1:0] sample_a,
   input  logic signed [rsmp_pkg::SAMPLE_W-1:0] sample_b,
   input  logic        [rsmp_pkg::FRAC_W-1:0]   frac,
   output logic signed [rsmp_pkg::SAMPLE_W-1:0] result
);
   import rsmp_pkg::*;

   localparam int UP = (FRACTION_BITS >= FRAC_W) ? FRACTION_BITS - FRAC_W : 0;
   localparam int DN = (FRACTION_BITS <  FRAC_W) ? FRAC_W - FRACTION_BITS : 0;
   localparam int WW = FRACTION_BITS + FRAC_W;
   localparam int PW = FRACTION_BITS + SAMPLE_W + 2;
   localparam int NW = PW + 1;

   logic [WW-1:0]            w_wide;
   logic [FRACTION_BITS-1:0] weight;
   logic signed [SAMPLE_W:0] diff;
   logic signed [PW-1:0]     prod_in;
   logic signed [PW-1:0]     prod_ff;
   logic signed [SAMPLE_W-1:0] a_ff;
   logic signed [NW-1:0]     num;
   logic        [NW-1:0]     quot;
   logic                     trunc_up;
   logic        [NW-1:0]     quot_adj;

   always_comb begin
      w_wide  = (WW'(frac) << UP) >> DN;
      weight  = w_wide[FRACTION_BITS-1:0];
      diff    = $signed({sample_b[SAMPLE_W-1], sample_b})
              - $signed({sample_a[SAMPLE_W-1], sample_a});
      prod_in = diff * $signed({1'b0, weight});
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         a_ff    <= sample_a;
      end
   end

   always_comb begin
      num      = (NW'(a_ff) <<< FRACTION_BITS) + NW'(prod_ff);
      quot     = num >>> FRACTION_BITS;
      trunc_up = num[NW-1] && (num[FRACTION_BITS-1:0] != '0);
      quot_adj = quot + {{(NW-1){1'b0}}, trunc_up};
      result   = quot_adj[SAMPLE_W-1:0];
   end

endmodule

/* sv/rsmp_divrem.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsmp_divrem: remainder unit for skipped output positions
// Restoring division, one dividend bit a cycle; returns the offset of the
// first position past the gap, (divisor - d mod divisor) mod divisor.
// ---------------------------------------------------------------------------
module rsmp_divrem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rsmp_pkg::DIVD_W-1:0]   dividend,
   input  logic [rsmp_pkg::STEP_W-1:0]   divisor,
   output logic                          done,
   output logic [rsmp_pkg::POS_W-1:0]    offset
);
   import rsmp_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic             busy_ff,  busy_in;
   logic             done_ff,  done_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;
   logic [DIVD_W-1:0] divd_ff, divd_in;
   logic [POS_W-1:0] rem_ff,   rem_in;
   logic [POS_W-1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      divd_in = divd_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff[POS_W-2:0], divd_ff[DIVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVD_W);
         divd_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = (trial >= POS_W'(divisor)) ? trial - POS_W'(divisor) : trial;
         divd_in = {divd_ff[DIVD_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      divd_ff <= divd_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign offset = (rem_ff == '0) ? '0 : POS_W'(divisor) - rem_ff;

endmodule

/* sv/linear_interp_resampler.sv */
`timescale 1ns / 1ps
// Order: the last output of an item is held back and leaves through ST_GAPEND
// and ST_FLUSH once the item's gaps are finished.
// Flow: one item at a time; a gap that would hold more than MAX_UPSAMPLE
// outputs is ended early and the remainder unit finds the next offset.
// Reset: synchronous; clears the sample history and offset, step to 1.0.
// ---------------------------------------------------------------------------
// linear_interp_resampler: linear interpolation sample rate converter
// Sequencer steps output positions through one adder, blends samples in a
// shared multiplier and holds one result back to mark the last of an item.
// ---------------------------------------------------------------------------
module linear_interp_resampler #(
   parameter int MAX_UPSAMPLE  = rsmp_pkg::DEF_MAX_UPSAMPLE,
   parameter int FRACTION_BITS = rsmp_pkg::DEF_FRACTION_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // [15:0] sample_in
   input  logic                          req_tlast,   // end_of_stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // [15:0] sample_out
   output logic                          rsp_tlast,   // run_last
   output logic                          rsp_tuser,   // [0] stream_done
   input  logic                          csr_we,
   input  logic [rsmp_pkg::STEP_W-1:0]   csr_wdata
);
   import rsmp_pkg::*;

   localparam int CNT_W = $clog2(MAX_UPSAMPLE + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_PUSH, ST_REM, ST_GAPEND, ST_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_W-1:0]   step_ff,  step_in;
   logic [SAMPLE_W-1:0] prev_ff,  prev_in;
   logic                have_ff,  have_in;
   logic [POS_W-1:0]    off_ff,   off_in;
   logic [SAMPLE_W-1:0] a_ff,     a_in;
   logic [SAMPLE_W-1:0] b_ff,     b_in;
   logic                eos_ff,   eos_in;
   logic                tail_ff,  tail_in;
   logic [POS_W-1:0]    pos_ff,   pos_in;
   logic [CNT_W-1:0]    cnt_ff,   cnt_in;
   logic [SAMPLE_W-1:0] pend_ff,  pend_in;
   logic                pendv_ff, pendv_in;
   logic                outv_ff,  outv_in;
   logic [SAMPLE_W-1:0] outd_ff,  outd_in;
   logic                outl_ff,  outl_in;
   logic                outs_ff,  outs_in;

   logic [STEP_W-1:0]   step_eff;
   logic                out_free;
   logic                accept;
   logic                interp_load;
   logic [SAMPLE_W-1:0] interp_result;
   logic                div_start;
   logic                div_done;
   logic [POS_W-1:0]    div_offset;
   logic [DIVD_W-1:0]   div_dividend;

   assign step_eff   = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign out_free   = !outv_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign div_dividend = DIVD_W'(POS_ONE - pos_ff);

   rsmp_interp #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_interp (
      .clock    (clock),
      .load     (interp_load),
      .sample_a (a_ff),
      .sample_b (b_ff),
      .frac     (pos_ff[FRAC_W-1:0]),
      .result   (interp_result)
   );

   rsmp_divrem u_divrem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (step_eff),
      .done     (div_done),
      .offset   (div_offset)
   );

   always_comb begin
      state_in    = state_ff;
      step_in     = csr_we ? csr_wdata : step_ff;
      prev_in     = prev_ff;
      have_in     = have_ff;
      off_in      = off_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      eos_in      = eos_ff;
      tail_in     = tail_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      pendv_in    = pendv_ff;
      outv_in     = outv_ff && !rsp_tready;
      outd_in     = outd_ff;
      outl_in     = outl_ff;
      outs_in     = outs_ff;
      interp_load = 1'b0;
      div_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in   = prev_ff;
               b_in   = req_tdata;
               eos_in = req_tlast;
               pos_in = off_ff;
               cnt_in = '0;
               if (have_ff) begin
                  tail_in  = 1'b0;
                  state_in = ST_CHECK;
               end else if (req_tlast) begin
                  a_in     = req_tdata;
                  tail_in  = 1'b1;
                  state_in = ST_CHECK;
               end else begin
                  prev_in = req_tdata;
                  have_in = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (pos_ff >= POS_ONE) begin
               off_in   = pos_ff - POS_ONE;
               state_in = ST_GAPEND;
            end else if (cnt_ff == CNT_W'(MAX_UPSAMPLE)) begin
               div_start = 1'b1;
               state_in  = ST_REM;
            end else begin
               interp_load = 1'b1;
               pos_in      = pos_ff + POS_W'(step_eff);
               cnt_in      = cnt_ff + 1'b1;
               state_in    = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!pendv_ff || out_free) begin
               if (pendv_ff) begin
                  outv_in = 1'b1;
                  outd_in = pend_ff;
                  outl_in = 1'b0;
                  outs_in = 1'b0;
               end
               pend_in  = interp_result;
               pendv_in = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_REM: begin
            if (div_done) begin
               off_in   = div_offset;
               state_in = ST_GAPEND;
            end
         end
         ST_GAPEND: begin
            if (eos_ff && !tail_ff) begin
               a_in     = b_ff;
               pos_in   = off_ff;
               cnt_in   = '0;
               tail_in  = 1'b1;
               state_in = ST_CHECK;
            end else begin
               if (eos_ff) begin
                  prev_in = '0;
                  have_in = 1'b0;
                  off_in  = '0;
               end else begin
                  prev_in = b_ff;
                  have_in = 1'b1;
               end
               state_in = pendv_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               outv_in  = 1'b1;
               outd_in  = pend_ff;
               outl_in  = 1'b1;
               outs_in  = eos_ff;
               pendv_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_RESET;
         prev_ff  <= '0;
         have_ff  <= 1'b0;
         off_ff   <= '0;
         pendv_ff <= 1'b0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         prev_ff  <= prev_in;
         have_ff  <= have_in;
         off_ff   <= off_in;
         pendv_ff <= pendv_in;
         outv_ff  <= outv_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      eos_ff  <= eos_in;
      tail_ff <= tail_in;
      pos_ff  <= pos_in;
      cnt_ff  <= cnt_in;
      pend_ff <= pend_in;
      outd_ff <= outd_in;
      outl_ff <= outl_in;
      outs_ff <= outs_in;
   end

   assign rsp_tvalid = outv_ff;
   assign rsp_tdata  = outd_ff;
   assign rsp_tlast  = outl_ff;
   assign rsp_tuser  = outs_ff;

endmodule
